// ----- rtl/core/vau_pkg.sv -----
`timescale 1ns / 1ps

package vau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_MAX      = 24;
  localparam int QW            = FRAC_MAX + 1;

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_NEG    = 4'd2;
  localparam logic [3:0] OP_SCALE  = 4'd3;
  localparam logic [3:0] OP_CROSS  = 4'd4;
  localparam logic [3:0] OP_DOT    = 4'd5;
  localparam logic [3:0] OP_LENGTH = 4'd6;
  localparam logic [3:0] OP_NORM   = 4'd7;
  localparam logic [3:0] OP_EQUAL  = 4'd8;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scale;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               equal;
    logic               saturated;
    logic               zero_length;
  } res_t;

  typedef struct packed {
    logic [3:0]            op;
    logic [2:0][31:0]      a;
    logic [2:0][31:0]      r;
    logic [31:0]           sc;
    logic                  eq;
    logic                  sat;
    logic                  zl;
    logic [63:0]           sx;
    logic [63:0]           sr;
    logic [31:0]           len;
    logic [2:0][32:0]      rem;
    logic [2:0][QW-1:0]    nlo;
    logic [2:0][QW-1:0]    quo;
    logic [2:0]            neg;
  } pipe_t;

  typedef struct packed {
    logic [31:0] v;
    logic        s;
  } sat_t;

  function automatic sat_t sat32(input logic signed [66:0] v);
    sat_t o;
    if (v > 67'sd2147483647) begin
      o.v = 32'h7fff_ffff;
      o.s = 1'b1;
    end else if (v < -67'sd2147483648) begin
      o.v = 32'h8000_0000;
      o.s = 1'b1;
    end else begin
      o.v = v[31:0];
      o.s = 1'b0;
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/vau_front.sv -----
`timescale 1ns / 1ps

module vau_front import vau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic [2:0] load,
  input  cmd_t       d,
  output pipe_t      q
);

  // operand select stage
  logic [3:0]              op_a;
  logic [2:0][31:0]        a_a;
  logic [2:0][31:0]        r_a;
  logic                    eq_a;
  logic                    sat_a;
  logic signed [5:0][31:0] ma;
  logic signed [5:0][31:0] mb;
  logic [2:0][31:0]        r_n;
  logic                    eq_n;
  logic                    sat_n;
  logic signed [5:0][31:0] ma_n;
  logic signed [5:0][31:0] mb_n;
  logic signed [31:0]      av [3];
  logic signed [31:0]      bv [3];
  sat_t                    t3 [3];

  // product stage
  logic [3:0]              op_b;
  logic [2:0][31:0]        a_b;
  logic [2:0][31:0]        r_b;
  logic                    eq_b;
  logic                    sat_b;
  logic signed [63:0]      p [6];

  pipe_t                   n;
  sat_t                    s0, s1, s2;

  function automatic sat_t rnd(input logic signed [66:0] v);
    logic signed [66:0] t;
    t = (v + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(t);
  endfunction

  always_comb begin
    av[0] = d.ax;  av[1] = d.ay;  av[2] = d.az;
    bv[0] = d.bx;  bv[1] = d.by;  bv[2] = d.bz;
    r_n   = '0;
    eq_n  = 1'b0;
    sat_n = 1'b0;
    for (int i = 0; i < 6; i++) begin
      ma_n[i] = '0;
      mb_n[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      t3[i] = sat32(67'(av[i]) + 67'(bv[i]));
    end
    case (d.op)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          t3[i] = sat32(67'(av[i]) + 67'(bv[i]));
          r_n[i] = t3[i].v;
        end
        sat_n = t3[0].s | t3[1].s | t3[2].s;
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          t3[i] = sat32(67'(av[i]) - 67'(bv[i]));
          r_n[i] = t3[i].v;
        end
        sat_n = t3[0].s | t3[1].s | t3[2].s;
      end
      OP_NEG: begin
        for (int i = 0; i < 3; i++) begin
          t3[i] = sat32(-67'(av[i]));
          r_n[i] = t3[i].v;
        end
        sat_n = t3[0].s | t3[1].s | t3[2].s;
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma_n[i] = av[i];
          mb_n[i] = d.scale;
        end
      end
      OP_CROSS: begin
        ma_n[0] = d.ay;  mb_n[0] = d.bz;
        ma_n[1] = d.az;  mb_n[1] = d.by;
        ma_n[2] = d.az;  mb_n[2] = d.bx;
        ma_n[3] = d.ax;  mb_n[3] = d.bz;
        ma_n[4] = d.ax;  mb_n[4] = d.by;
        ma_n[5] = d.ay;  mb_n[5] = d.bx;
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma_n[i] = av[i];
          mb_n[i] = bv[i];
        end
      end
      OP_LENGTH, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma_n[i] = av[i];
          mb_n[i] = av[i];
        end
      end
      OP_EQUAL: begin
        eq_n = (d.ax == d.bx) && (d.ay == d.by) && (d.az == d.bz);
      end
      default: begin
        eq_n = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      op_a  <= d.op;
      a_a   <= {d.az, d.ay, d.ax};
      r_a   <= r_n;
      eq_a  <= eq_n;
      sat_a <= sat_n;
      ma    <= ma_n;
      mb    <= mb_n;
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      op_b  <= op_a;
      a_b   <= a_a;
      r_b   <= r_a;
      eq_b  <= eq_a;
      sat_b <= sat_a;
      for (int i = 0; i < 6; i++) begin
        p[i] <= $signed(ma[i]) * $signed(mb[i]);
      end
    end
  end

  always_comb begin
    n     = '0;
    n.op  = op_b;
    n.a   = a_b;
    n.r   = r_b;
    n.eq  = eq_b;
    n.sat = sat_b;
    s0    = rnd(67'(p[0]));
    s1    = rnd(67'(p[1]));
    s2    = rnd(67'(p[2]));
    case (op_b)
      OP_SCALE: begin
        n.r   = {s2.v, s1.v, s0.v};
        n.sat = s0.s | s1.s | s2.s;
      end
      OP_CROSS: begin
        s0    = rnd(67'(p[0]) - 67'(p[1]));
        s1    = rnd(67'(p[2]) - 67'(p[3]));
        s2    = rnd(67'(p[4]) - 67'(p[5]));
        n.r   = {s2.v, s1.v, s0.v};
        n.sat = s0.s | s1.s | s2.s;
      end
      OP_DOT: begin
        s0    = rnd(67'(p[0]) + 67'(p[1]) + 67'(p[2]));
        n.sc  = s0.v;
        n.sat = s0.s;
      end
      OP_LENGTH, OP_NORM: begin
        n.sx = p[0] + p[1] + p[2];
      end
      default: begin
        n.sx = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      q <= n;
    end
  end

endmodule

// ----- rtl/core/vau_sqrt_cell.sv -----
`timescale 1ns / 1ps

module vau_sqrt_cell import vau_pkg::*; #(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  load,
  input  pipe_t d,
  output pipe_t q
);

  localparam logic [63:0] BIT = 64'd1 << (2 * K);

  logic [63:0] t;
  pipe_t       n;

  always_comb begin
    n = d;
    t = d.sr + BIT;
    if (d.sx >= t) begin
      n.sx = d.sx - t;
      n.sr = (d.sr >> 1) + BIT;
    end else begin
      n.sr = d.sr >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= n;
    end
  end

endmodule

// ----- rtl/core/vau_root_end.sv -----
`timescale 1ns / 1ps

module vau_root_end import vau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  load,
  input  pipe_t d,
  output pipe_t q
);

  logic [63:0] len64;
  logic [31:0] len;
  logic [31:0] m;
  logic [63:0] num;
  pipe_t       n;

  always_comb begin
    n     = d;
    len64 = d.sr + 64'(d.sx > d.sr);
    len   = len64[31:0];
    n.len = len;
    m     = '0;
    num   = '0;
    if (d.op == OP_LENGTH) begin
      if (len > 32'h7fff_ffff) begin
        n.sc  = 32'h7fff_ffff;
        n.sat = 1'b1;
      end else begin
        n.sc = len;
      end
    end
    if (d.op == OP_NORM) begin
      n.zl = (len == 32'd0);
    end
    for (int i = 0; i < 3; i++) begin
      m        = d.a[i][31] ? (32'd0 - d.a[i]) : d.a[i];
      num      = ({32'd0, m} << FRAC_BITS) + 64'(len >> 1);
      n.rem[i] = 33'(num >> (FRAC_BITS + 1));
      n.nlo[i] = QW'(num);
      n.quo[i] = '0;
      n.neg[i] = d.a[i][31];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= n;
    end
  end

endmodule

// ----- rtl/core/vau_div_cell.sv -----
`timescale 1ns / 1ps

module vau_div_cell import vau_pkg::*; #(
  parameter int I = 0
) (
  input  logic  clk,
  input  logic  load,
  input  pipe_t d,
  output pipe_t q
);

  logic [32:0] part;
  pipe_t       n;

  always_comb begin
    n    = d;
    part = '0;
    for (int i = 0; i < 3; i++) begin
      part = {d.rem[i][31:0], d.nlo[i][I]};
      if (part >= {1'b0, d.len}) begin
        n.rem[i]    = part - {1'b0, d.len};
        n.quo[i][I] = 1'b1;
      end else begin
        n.rem[i] = part;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= n;
    end
  end

endmodule

// ----- rtl/core/vector3_arithmetic_unit_core.sv -----
`timescale 1ns / 1ps

// channel | valid     | stall     | payload
// --------+-----------+-----------+-------------
// command | cmd_valid | cmd_stall | cmd (cmd_t)
// result  | res_valid | res_stall | res (res_t)
//
// The pipe takes one item per cycle while res_stall is low. Depth comes from
// the front stages, root chain (one cell per root bit, 32 cells), root end,
// divide chain (FRAC_BITS + 1 cells, three lanes each) and result register.
// rst is synchronous and clears only the stage valid bits.
// Each stage advances when empty or when the next one moves, so bubbles fill
// while a result waits under res_stall.

module vector3_arithmetic_unit_core import vau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_stall,
  input  cmd_t  cmd,
  output logic  res_valid,
  input  logic  res_stall,
  output res_t  res
);

  localparam int NP = FRAC_BITS + 35;
  localparam int NS = NP + 3;

  logic [NS-1:0] v;
  logic [NS-1:0] v_next;
  logic [NS:0]   rdy;
  pipe_t         pp [NP];
  pipe_t         last;
  res_t          res_next;

  assign rdy[NS] = ~res_stall;

  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_rdy
      assign rdy[gi] = ~v[gi] | rdy[gi+1];
    end
  endgenerate

  assign cmd_stall = ~rdy[0];
  assign res_valid = v[NS-1];

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (rdy[i]) begin
        v_next[i] = (i == 0) ? cmd_valid : v[(i == 0) ? 0 : i - 1];
      end else begin
        v_next[i] = v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  vau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk  (clk),
    .load (rdy[2:0]),
    .d    (cmd),
    .q    (pp[0])
  );

  generate
    for (gi = 0; gi < 32; gi++) begin : g_sqrt
      vau_sqrt_cell #(.K(31 - gi)) u_cell (
        .clk  (clk),
        .load (rdy[gi+3]),
        .d    (pp[gi]),
        .q    (pp[gi+1])
      );
    end
  endgenerate

  vau_root_end #(.FRAC_BITS(FRAC_BITS)) u_root_end (
    .clk  (clk),
    .load (rdy[35]),
    .d    (pp[32]),
    .q    (pp[33])
  );

  generate
    for (gi = 0; gi <= FRAC_BITS; gi++) begin : g_div
      vau_div_cell #(.I(FRAC_BITS - gi)) u_cell (
        .clk  (clk),
        .load (rdy[gi+36]),
        .d    (pp[gi+33]),
        .q    (pp[gi+34])
      );
    end
  endgenerate

  assign last = pp[NP-1];

  always_comb begin
    res_next.rx          = last.r[0];
    res_next.ry          = last.r[1];
    res_next.rz          = last.r[2];
    res_next.scalar_out  = last.sc;
    res_next.equal       = last.eq;
    res_next.saturated   = last.sat;
    res_next.zero_length = last.zl;
    if (last.op == OP_NORM && !last.zl) begin
      res_next.rx = last.neg[0] ? 32'd0 - 32'(last.quo[0]) : 32'(last.quo[0]);
      res_next.ry = last.neg[1] ? 32'd0 - 32'(last.quo[1]) : 32'(last.quo[1]);
      res_next.rz = last.neg[2] ? 32'd0 - 32'(last.quo[2]) : 32'(last.quo[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      res <= res_next;
    end
  end

endmodule
